/* design/sha1sh_pkg.sv */
package sha1sh_pkg;

	typedef logic [31:0] word_t;
	typedef logic [4:0][31:0] hash_t;
	typedef logic [15:0][31:0] block_t;
	typedef logic [6:0] round_t;

	localparam hash_t H_INIT = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] FILL_LAST = 6'd63;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [2:0] WORD_LAST = 3'd4;
	localparam round_t ROUND_LAST = 7'd79;
	localparam round_t SCHED_START = 7'd16;
	localparam round_t F1_LAST = 7'd19;
	localparam round_t F2_LAST = 7'd39;
	localparam round_t F3_LAST = 7'd59;
	localparam logic [63:0] BLOCK_BITS = 64'd512;
	localparam logic [2:0] ADDR_KEEP = 3'd0;

	function automatic word_t round_f(round_t r, word_t b, word_t c, word_t d);
		word_t f;
		if (r <= F1_LAST) begin
			f = (b & c) | (~b & d);
		end else if (r <= F2_LAST) begin
			f = b ^ c ^ d;
		end else if (r <= F3_LAST) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

	function automatic word_t round_k(round_t r);
		word_t k;
		if (r <= F1_LAST) begin
			k = 32'h5A827999;
		end else if (r <= F2_LAST) begin
			k = 32'h6ED9EBA1;
		end else if (r <= F3_LAST) begin
			k = 32'h8F1BBCDC;
		end else begin
			k = 32'hCA62C1D6;
		end
		return k;
	endfunction

endpackage

/* design/sha1_stream_hasher.sv */
// channel   dir  signals                               contents
// s_*       in   s_tvalid s_tready s_tdata s_tuser    data_byte, byte_valid, end_of_message
//                s_tlast
// m_*       out  m_tvalid m_tready m_tdata m_tuser    digest_word, word_index, last_word
//                m_tlast
// apb       in   psel penable pwrite paddr pwdata     keep_after_digest at byte address 0
//                prdata pready
//
// bytes go in one per cycle until the 64-byte buffer is full, then the input
// stalls for the 80 rounds of the single round unit and the chaining add
// end of message: a padding step, then the rounds and the chaining add, twice when
// the length spills into a second final block, then five digest words held until taken
// reset is asynchronous and loads the initial chaining words; the block buffer
// is not cleared, padding overwrites every byte past the fill count
// s_tready is low whenever the round unit runs or a digest waits on m_*
module sha1_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] byte_valid
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] word_index
	output logic        m_tlast,   // last_word
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_BLKEND,
		ST_PAD,
		ST_OUT
	} state_t;

	state_t state_q;

	// persistent message state
	sha1sh_pkg::hash_t  chain_q;
	sha1sh_pkg::block_t blk_q;
	logic [5:0]         fill_q;
	logic [63:0]        total_q;
	logic               keep_q;

	// round unit and finalize scratch
	sha1sh_pkg::block_t w_q;      // schedule window, w_q[0] is the oldest word
	sha1sh_pkg::hash_t  work_q;   // a at [0] through e at [4]
	sha1sh_pkg::hash_t  hb_q;     // chaining input of the block in flight
	sha1sh_pkg::hash_t  hw_q;     // finished digest
	logic [63:0]        len_q;
	sha1sh_pkg::round_t round_q;
	logic               fin_q;    // block in flight is a padded final block
	logic               second_q; // length still needs its own block
	logic               eom_q;    // finalize once the full block is folded in
	logic [2:0]         out_idx_q;

	logic               in_acc;
	logic               out_acc;
	logic               cfg_wr;
	sha1sh_pkg::block_t blk_nxt;
	sha1sh_pkg::block_t pad_blk;
	sha1sh_pkg::block_t len_blk;
	sha1sh_pkg::hash_t  res;
	logic [63:0]        len_nxt;
	sha1sh_pkg::word_t  wt;
	sha1sh_pkg::word_t  t;

	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = m_tvalid && m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = hw_q[out_idx_q];
	assign m_tuser  = out_idx_q;
	assign m_tlast  = (out_idx_q == sha1sh_pkg::WORD_LAST);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
	assign prdata = (paddr == sha1sh_pkg::ADDR_KEEP) ? {31'd0, keep_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= 1'b0;
		end else if (cfg_wr) begin
			keep_q <= pwdata[0];
		end
	end

	// byte lands big-endian inside its word
	always_comb begin
		blk_nxt = blk_q;
		if (s_tuser) begin
			blk_nxt[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] = s_tdata;
		end
	end

	// padded final block: held bytes, 0x80, zeros, length if it fits
	assign len_nxt = total_q + {55'd0, fill_q, 3'b000};

	always_comb begin
		logic [5:0] pos;
		logic [7:0] pbyte;
		pad_blk = '0;
		for (int wi = 0; wi < 16; wi++) begin
			for (int bi = 0; bi < 4; bi++) begin
				pos = {4'(wi), 2'(bi)};
				if (pos < fill_q) begin
					pbyte = blk_q[wi][(3 - bi) * 8 +: 8];
				end else if (pos == fill_q) begin
					pbyte = sha1sh_pkg::PAD_BYTE;
				end else begin
					pbyte = 8'd0;
				end
				pad_blk[wi][(3 - bi) * 8 +: 8] = pbyte;
			end
		end
		if (fill_q < sha1sh_pkg::LEN_POS) begin
			pad_blk[14] = len_nxt[63:32];
			pad_blk[15] = len_nxt[31:0];
		end
	end

	always_comb begin
		len_blk     = '0;
		len_blk[14] = len_q[63:32];
		len_blk[15] = len_q[31:0];
	end

	// shared round unit
	always_comb begin
		sha1sh_pkg::word_t mix;
		mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		wt  = (round_q < sha1sh_pkg::SCHED_START) ? w_q[0] : {mix[30:0], mix[31]};
		t   = {work_q[0][26:0], work_q[0][31:27]}
			+ sha1sh_pkg::round_f(round_q, work_q[1], work_q[2], work_q[3])
			+ work_q[4] + sha1sh_pkg::round_k(round_q) + wt;
	end

	always_comb begin
		for (int i = 0; i < 5; i++) begin
			res[i] = hb_q[i] + work_q[i];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			chain_q   <= sha1sh_pkg::H_INIT;
			fill_q    <= '0;
			total_q   <= '0;
			round_q   <= '0;
			fin_q     <= 1'b0;
			second_q  <= 1'b0;
			eom_q     <= 1'b0;
			out_idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser) begin
							fill_q <= fill_q + 6'd1;
						end
						if (s_tuser && fill_q == sha1sh_pkg::FILL_LAST) begin
							total_q <= total_q + sha1sh_pkg::BLOCK_BITS;
							fin_q   <= 1'b0;
							eom_q   <= s_tlast;
							round_q <= '0;
							state_q <= ST_ROUND;
						end else if (s_tlast) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_ROUND: begin
					if (round_q == sha1sh_pkg::ROUND_LAST) begin
						state_q <= ST_BLKEND;
					end else begin
						round_q <= round_q + 7'd1;
					end
				end
				ST_BLKEND: begin
					if (!fin_q) begin
						chain_q <= res;
						state_q <= eom_q ? ST_PAD : ST_IDLE;
					end else if (second_q) begin
						second_q <= 1'b0;
						round_q  <= '0;
						state_q  <= ST_ROUND;
					end else begin
						out_idx_q <= '0;
						state_q   <= ST_OUT;
					end
				end
				ST_PAD: begin
					fin_q    <= 1'b1;
					second_q <= (fill_q >= sha1sh_pkg::LEN_POS);
					round_q  <= '0;
					state_q  <= ST_ROUND;
				end
				ST_OUT: begin
					if (out_acc) begin
						if (out_idx_q == sha1sh_pkg::WORD_LAST) begin
							if (!keep_q) begin
								chain_q <= sha1sh_pkg::H_INIT;
								fill_q  <= '0;
								total_q <= '0;
							end
							state_q <= ST_IDLE;
						end else begin
							out_idx_q <= out_idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					blk_q <= blk_nxt;
					if (s_tuser && fill_q == sha1sh_pkg::FILL_LAST) begin
						w_q    <= blk_nxt;
						hb_q   <= chain_q;
						work_q <= chain_q;
					end
				end
			end
			ST_ROUND: begin
				w_q    <= {wt, w_q[15:1]};
				work_q <= {work_q[3], work_q[2], {work_q[1][1:0], work_q[1][31:2]},
					work_q[0], t};
			end
			ST_BLKEND: begin
				if (fin_q && second_q) begin
					w_q    <= len_blk;
					hb_q   <= res;
					work_q <= res;
				end else if (fin_q) begin
					hw_q <= res;
				end
			end
			ST_PAD: begin
				w_q    <= pad_blk;
				len_q  <= len_nxt;
				hb_q   <= chain_q;
				work_q <= chain_q;
			end
			default: begin
			end
		endcase
	end

	// checks
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		round_q <= sha1sh_pkg::ROUND_LAST)
		else $error("round counter past last round");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input open while digest pending");

	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_tlast) |=> s_tready)
		else $error("block not idle after last digest word");

	a_fill_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_acc && state_q != ST_OUT) |=> $stable(fill_q))
		else $error("fill count moved without a request");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= sha1sh_pkg::WORD_LAST))
		else $error("digest word index out of range");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

	// bus fields: request side, digest side and configuration port
	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tuser;   // [0] byte_valid
	logic        s_tlast;   // end_of_message
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [31:0] digest_word
	logic [2:0]  m_tuser;   // [2:0] word_index
	logic        m_tlast;   // last_word
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// address with no register behind it, writes there must be ignored
	localparam logic [2:0] ADDR_UNUSED = 3'd4;
	// quiet gap after the last digest word before the next phase
	localparam int SETTLE_CYCLES = 200;
	// receiver hold-off long enough to back the block up into its input
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 70;

	typedef logic [4:0][31:0] hash_state_t;
	typedef logic [15:0][31:0] msg_block_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_beat_t;

	// running sha-1 state plus the digest words still owed by the block
	class digest_scoreboard;
		localparam hash_state_t CHAIN_INIT = {
			32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
		};
		localparam int DIGEST_WORDS = 5;
		localparam int LENGTH_BYTE = 56;

		hash_state_t  chain;
		msg_block_t   buffer;
		logic [5:0]   fill;
		logic [63:0]  bit_count;
		bit           keep;
		int           mismatches;
		digest_beat_t owed_words[$];

		function new();
			chain = CHAIN_INIT;
			buffer = '0;
			fill = '0;
			bit_count = '0;
			keep = 1'b0;
			mismatches = 0;
		endfunction

		function void put_byte(inout msg_block_t blk, input int pos, input logic [7:0] v);
			blk[pos / 4][(3 - pos % 4) * 8 +: 8] = v;
		endfunction

		function hash_state_t compress_block(hash_state_t h, msg_block_t blk);
			msg_block_t w;
			logic [31:0] a, b, c, d, e, f, k, t;
			w = blk;
			a = h[0];
			b = h[1];
			c = h[2];
			d = h[3];
			e = h[4];
			for (int r = 0; r < 80; r++) begin
				// message schedule kept in a 16-word ring
				if (r >= 16) begin
					t = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16];
					w[r % 16] = {t[30:0], t[31]};
				end
				if (r < 20) begin
					f = (b & c) | (~b & d);
					k = 32'h5A827999;
				end else if (r < 40) begin
					f = b ^ c ^ d;
					k = 32'h6ED9EBA1;
				end else if (r < 60) begin
					f = (b & c) | (b & d) | (c & d);
					k = 32'h8F1BBCDC;
				end else begin
					f = b ^ c ^ d;
					k = 32'hCA62C1D6;
				end
				t = {a[26:0], a[31:27]} + f + e + k + w[r % 16];
				e = d;
				d = c;
				c = {b[1:0], b[31:2]};
				b = a;
				a = t;
			end
			h[0] += a;
			h[1] += b;
			h[2] += c;
			h[3] += d;
			h[4] += e;
			return h;
		endfunction

		function void absorb_request(logic [7:0] data, logic valid, logic last);
			hash_state_t  h;
			msg_block_t   blk;
			logic [63:0]  length_bits;
			digest_beat_t beat;
			int           p;
			if (valid) begin
				put_byte(buffer, fill, data);
				fill = fill + 6'd1;
				if (fill == 6'd0) begin
					chain = compress_block(chain, buffer);
					bit_count += 64'd512;
				end
			end
			if (!last) return;
			h = chain;
			blk = buffer;
			p = fill;
			length_bits = bit_count + 64'(p) * 64'd8;
			put_byte(blk, p, 8'h80);
			for (int q = p + 1; q < 64; q++) put_byte(blk, q, 8'h00);
			// no room for the length field: spill into a second final block
			if (p >= LENGTH_BYTE) begin
				h = compress_block(h, blk);
				blk = '0;
			end
			blk[14] = length_bits[63:32];
			blk[15] = length_bits[31:0];
			h = compress_block(h, blk);
			for (int j = 0; j < DIGEST_WORDS; j++) begin
				beat.word = h[j];
				beat.index = 3'(j);
				beat.last = (j == DIGEST_WORDS - 1);
				owed_words.push_back(beat);
			end
			if (!keep) begin
				chain = CHAIN_INIT;
				fill = '0;
				bit_count = '0;
			end
		endfunction

		function void check_word(logic [31:0] word, logic [2:0] index, logic last);
			digest_beat_t want;
			if (owed_words.size() == 0) begin
				$error("unexpected digest word %h index %0d", word, index);
				mismatches++;
				return;
			end
			want = owed_words.pop_front();
			if (word !== want.word) begin
				$error("digest_word: expected %h, actual %h", want.word, word);
				mismatches++;
			end
			if (index !== want.index) begin
				$error("word_index: expected %0d, actual %0d", want.index, index);
				mismatches++;
			end
			if (last !== want.last) begin
				$error("last_word: expected %0d, actual %0d", want.last, last);
				mismatches++;
			end
		endfunction

		function int owed();
			return owed_words.size();
		endfunction
	endclass

	digest_scoreboard sb;
	bit source_burst;
	bit sink_burst;
	bit hold_sink;

	sha1_stream_hasher dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	// digest monitor, sampled at the edge so drive order does not matter
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser, m_tlast);
	end

	// receiver: random stalls, bursts with none, one long hold on request
	initial begin
		int gap;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_sink) begin
				hold_sink = 1'b0;
				gap = LONG_HOLD_CYCLES;
			end else if (sink_burst) begin
				gap = 0;
			end else begin
				gap = $urandom_range(0, 17);
			end
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			if ($urandom_range(0, 19) == 0) sink_burst = !sink_burst;
		end
	end

	// one request on the input side, after a random idle gap unless the source is in a burst
	task automatic offer(input logic [7:0] data, input logic valid, input logic last);
		int gap;
		gap = source_burst ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= data;
		s_tuser <= valid;
		s_tlast <= last;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		sb.absorb_request(data, valid, last);
	endtask

	// stop sending until every digest word is in, then let the round unit settle
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.owed() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic write, input logic [2:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// write the mode with junk in the upper bits, then read it back
	task automatic set_keep_mode(input bit keep);
		logic [31:0] wdata;
		logic [31:0] rdata;
		wdata = $urandom();
		wdata[0] = keep;
		apb_access(1'b1, sha1sh_pkg::ADDR_KEEP, wdata, rdata);
		sb.keep = keep;
		apb_access(1'b0, sha1sh_pkg::ADDR_KEEP, 32'd0, rdata);
		if (rdata !== {31'd0, keep}) begin
			$error("keep_after_digest readback: expected %h, actual %h", {31'd0, keep}, rdata);
			sb.mismatches++;
		end
	endtask

	// message of random bytes, end marked on the last byte or by a bare end request,
	// with ignored idle requests sprinkled in
	task automatic send_message(input int len);
		bit end_on_byte;
		end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
		source_burst = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 7) == 0) offer(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			offer(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
		end
		if (!end_on_byte) offer(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	// random message lengths, trimmed so the phase stays near its item budget
	task automatic random_phase();
		int count;
		int len;
		count = 0;
		while (count < PHASE_ITEMS) begin
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
			if (count + len + 1 > PHASE_ITEMS) len = PHASE_ITEMS - count - 1;
			send_message(len);
			count += len + 1;
		end
	endtask

	initial begin
		logic [31:0] rdata;
		sb = new();
		source_burst = 1'b0;
		sink_burst = 1'b0;
		hold_sink = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		s_tlast <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: digest mode
		set_keep_mode(1'b0);
		offer(8'h00, 1'b0, 1'b1);   // empty message
		offer(8'hA5, 1'b0, 1'b0);   // idle request, data ignored
		offer(8'h00, 1'b1, 1'b1);   // lowest byte alone
		offer(8'hFF, 1'b1, 1'b1);   // highest byte alone
		offer(8'h61, 1'b1, 1'b0);   // "abc"
		offer(8'h62, 1'b1, 1'b0);
		offer(8'h63, 1'b1, 1'b1);
		offer(8'hFF, 1'b0, 1'b0);
		offer(8'h80, 1'b1, 1'b0);
		offer(8'h5A, 1'b0, 1'b1);   // bare end after held bytes
		wait_drain();

		// directed: peek mode, repeated peeks give the same digest
		set_keep_mode(1'b1);
		offer(8'h01, 1'b1, 1'b0);
		offer(8'h7F, 1'b1, 1'b1);
		offer(8'hC3, 1'b0, 1'b1);
		offer(8'hFE, 1'b1, 1'b1);
		wait_drain();
		// write to an unused address must leave the mode alone
		apb_access(1'b1, ADDR_UNUSED, 32'h0000_0000, rdata);
		offer(8'h3C, 1'b0, 1'b1);
		wait_drain();

		// back to digest mode: the open message closes on the first end
		set_keep_mode(1'b0);
		send_message(2);
		wait_drain();

		// peek mode: one message grown through the length field boundary
		// (55, 56 and 63 held bytes) and across a full block, with the
		// receiver holding off long enough that the input backs up
		set_keep_mode(1'b1);
		hold_sink = 1'b1;
		send_message(55);
		send_message(1);
		send_message(7);
		send_message(1);
		send_message(5);
		wait_drain();

		// digest mode again: the open message closes first, then random lengths
		set_keep_mode(1'b0);
		random_phase();
		wait_drain();

		if (sb.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/sha1sh_pkg.sv
design/sha1_stream_hasher.sv
test/tb.sv
